// ===== rtl/imu_gb_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the IMU gyro bias / free-fall block.
// No dependencies.
package imu_gb_pkg;

    localparam int DATA_W = 16;
    localparam int SQ_W   = 31;
    localparam int MAG_W  = 32;

    localparam logic [DATA_W-1:0] FALL_THR_RST = 16'd835;

    typedef struct packed {
        logic signed [DATA_W-1:0] accel_x;
        logic signed [DATA_W-1:0] accel_y;
        logic signed [DATA_W-1:0] accel_z;
        logic signed [DATA_W-1:0] gyro_x;
        logic signed [DATA_W-1:0] gyro_y;
        logic signed [DATA_W-1:0] gyro_z;
    } t_imu_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] out_accel_x;
        logic signed [DATA_W-1:0] out_accel_y;
        logic signed [DATA_W-1:0] out_accel_z;
        logic signed [DATA_W-1:0] rate_x;
        logic signed [DATA_W-1:0] rate_y;
        logic signed [DATA_W-1:0] rate_z;
        logic                     falling;
        logic                     fall_onset;
    } t_imu_out;

    typedef struct packed {
        logic busy;
        logic done;
    } t_calib_status;

    typedef struct packed {
        logic load;
        logic step;
    } t_div_ctl;

endpackage

// ===== rtl/imu_gb_div.sv =====
`timescale 1ns / 1ps
// One-axis bias divider: floor(sum / CALIB_SAMPLES) by reciprocal multiplication,
// magnitude registered on load, quotient registered on the following step.
// Depends on imu_gb_pkg.
module imu_gb_div #(
    parameter int CALIB_SAMPLES = 50
) (
    input  logic                                             i_clk,
    input  imu_gb_pkg::t_div_ctl                             i_ctl,
    input  logic signed [15+$clog2(CALIB_SAMPLES):0]         i_sum,
    output logic signed [imu_gb_pkg::DATA_W-1:0]             o_bias
);
    import imu_gb_pkg::*;

    localparam int SUM_W   = DATA_W + $clog2(CALIB_SAMPLES);
    localparam int SHIFT   = SUM_W + $clog2(CALIB_SAMPLES);
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    // ceil(2^SHIFT / n): exact floor for every magnitude below 2^SUM_W
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((64'd1 << SHIFT)
        + 64'(CALIB_SAMPLES) - 64'd1) / 64'(CALIB_SAMPLES));

    logic [SUM_W-1:0]  w_sum_u;
    logic [SUM_W-1:0]  w_mag;
    logic [PROD_W-1:0] w_prod;

    logic [SUM_W-1:0]  r_mag;
    logic [DATA_W-1:0] r_quo;
    logic              r_neg;

    // negative sums: floor(s/n) = -((-s + n - 1) / n), and -s + n - 1 = ~s + n
    assign w_sum_u = i_sum;
    assign w_mag   = i_sum[SUM_W-1] ? (~w_sum_u + SUM_W'(CALIB_SAMPLES)) : w_sum_u;
    assign w_prod  = PROD_W'(r_mag) * PROD_W'(RECIP);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_mag <= w_mag;
            r_neg <= i_sum[SUM_W-1];
        end else if (i_ctl.step) begin
            r_quo <= w_prod[SHIFT +: DATA_W];
        end
    end

    assign o_bias = r_neg ? (~r_quo + DATA_W'(1)) : r_quo;

endmodule

// ===== rtl/imu_gb_calib.sv =====
`timescale 1ns / 1ps
// Gyro bias calibration: sums the first CALIB_SAMPLES samples, then runs three dividers.
// Depends on imu_gb_pkg and imu_gb_div.
module imu_gb_calib #(
    parameter int CALIB_SAMPLES = 50
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_accept,
    input  logic signed [imu_gb_pkg::DATA_W-1:0] i_gyro_x,
    input  logic signed [imu_gb_pkg::DATA_W-1:0] i_gyro_y,
    input  logic signed [imu_gb_pkg::DATA_W-1:0] i_gyro_z,
    output logic signed [imu_gb_pkg::DATA_W-1:0] o_bias_x,
    output logic signed [imu_gb_pkg::DATA_W-1:0] o_bias_y,
    output logic signed [imu_gb_pkg::DATA_W-1:0] o_bias_z,
    output imu_gb_pkg::t_calib_status            o_status
);
    import imu_gb_pkg::*;

    localparam int SUM_W  = DATA_W + $clog2(CALIB_SAMPLES);
    localparam int CNT_W  = $clog2(CALIB_SAMPLES + 1);

    typedef enum logic [1:0] {
        ST_ACCUM,
        ST_LOAD,
        ST_DIVIDE,
        ST_DONE
    } t_state;

    t_state                   r_state;
    logic [CNT_W-1:0]         r_count;
    logic signed [SUM_W-1:0]  r_sum_x;
    logic signed [SUM_W-1:0]  r_sum_y;
    logic signed [SUM_W-1:0]  r_sum_z;
    t_calib_status            r_status;
    t_div_ctl                 w_div_ctl;

    assign w_div_ctl.load = (r_state == ST_LOAD);
    assign w_div_ctl.step = (r_state == ST_DIVIDE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_ACCUM;
            r_count  <= '0;
            r_sum_x  <= '0;
            r_sum_y  <= '0;
            r_sum_z  <= '0;
            r_status <= '0;
        end else begin
            unique case (r_state)
                ST_ACCUM: begin
                    if (i_accept) begin
                        r_sum_x <= r_sum_x + SUM_W'(i_gyro_x);
                        r_sum_y <= r_sum_y + SUM_W'(i_gyro_y);
                        r_sum_z <= r_sum_z + SUM_W'(i_gyro_z);
                        r_count <= r_count + CNT_W'(1);
                        if (r_count == CNT_W'(CALIB_SAMPLES - 1)) begin
                            r_state       <= ST_LOAD;
                            r_status.busy <= 1'b1;
                        end
                    end
                end
                ST_LOAD: begin
                    r_state <= ST_DIVIDE;
                end
                ST_DIVIDE: begin
                    r_state       <= ST_DONE;
                    r_status.busy <= 1'b0;
                    r_status.done <= 1'b1;
                end
                ST_DONE: begin
                    r_state <= ST_DONE;
                end
                default: begin
                    r_state <= ST_ACCUM;
                end
            endcase
        end
    end

    assign o_status = r_status;

    imu_gb_div #(.CALIB_SAMPLES(CALIB_SAMPLES)) u_div_x (
        .i_clk  (i_clk),
        .i_ctl  (w_div_ctl),
        .i_sum  (r_sum_x),
        .o_bias (o_bias_x)
    );

    imu_gb_div #(.CALIB_SAMPLES(CALIB_SAMPLES)) u_div_y (
        .i_clk  (i_clk),
        .i_ctl  (w_div_ctl),
        .i_sum  (r_sum_y),
        .o_bias (o_bias_y)
    );

    imu_gb_div #(.CALIB_SAMPLES(CALIB_SAMPLES)) u_div_z (
        .i_clk  (i_clk),
        .i_ctl  (w_div_ctl),
        .i_sum  (r_sum_z),
        .o_bias (o_bias_z)
    );

endmodule

// ===== rtl/imu_gyro_bias_and_free_fall_detect.sv =====
`timescale 1ns / 1ps
// IMU gyro bias removal and free-fall detection, top level.
// Depends on imu_gb_pkg and imu_gb_calib.
// Samples are registered in stage 1, then in r_out; one sample per cycle unless stalled.
// The first CALIB_SAMPLES samples give no result; then the bias divider (load, then one
// reciprocal multiply) stalls input through its load and divide states, once after reset.
// Synchronous active-low reset clears control and sums, sets threshold 835; biases load at
// the end of calibration.
module imu_gyro_bias_and_free_fall_detect #(
    parameter int CALIB_SAMPLES = 50
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  imu_gb_pkg::t_imu_in                  i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output imu_gb_pkg::t_imu_out                 o_out_data,
    input  logic                                 i_cfg_we,
    input  logic [imu_gb_pkg::DATA_W-1:0]        i_cfg_wdata
);
    import imu_gb_pkg::*;

    localparam logic [MAG_W-1:0] THR2_RST = MAG_W'(FALL_THR_RST) * MAG_W'(FALL_THR_RST);

    function automatic logic signed [DATA_W-1:0] sat_sub(
        input logic signed [DATA_W-1:0] g,
        input logic signed [DATA_W-1:0] b
    );
        logic signed [DATA_W:0] d;
        d = (DATA_W+1)'(g) - (DATA_W+1)'(b);
        if (d[DATA_W] != d[DATA_W-1]) begin
            sat_sub = d[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            sat_sub = d[DATA_W-1:0];
        end
    endfunction

    t_calib_status              w_status;
    logic signed [DATA_W-1:0]   w_bias_x;
    logic signed [DATA_W-1:0]   w_bias_y;
    logic signed [DATA_W-1:0]   w_bias_z;
    logic                       w_accept;
    logic                       w_adv;
    logic                       w_s1_ready;
    logic signed [2*DATA_W-1:0] w_sq_x;
    logic signed [2*DATA_W-1:0] w_sq_y;
    logic signed [2*DATA_W-1:0] w_sq_z;
    logic [MAG_W-1:0]           w_mag2;
    logic                       w_falling;
    t_imu_out                   n_out;

    logic [MAG_W-1:0]           r_thr2;
    logic                       r_s1_valid;
    t_imu_in                    r_s1_in;
    logic [SQ_W-1:0]            r_sq_x;
    logic [SQ_W-1:0]            r_sq_y;
    logic [SQ_W-1:0]            r_sq_z;
    logic                       r_out_valid;
    t_imu_out                   r_out;
    logic                       r_in_fall;

    assign w_adv      = !r_out_valid || !i_out_stall;
    assign w_s1_ready = !r_s1_valid || w_adv;
    assign o_in_stall = w_status.busy || !w_s1_ready;
    assign w_accept   = i_in_valid && !o_in_stall;

    imu_gb_calib #(.CALIB_SAMPLES(CALIB_SAMPLES)) u_calib (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept && !w_status.done),
        .i_gyro_x (i_in_data.gyro_x),
        .i_gyro_y (i_in_data.gyro_y),
        .i_gyro_z (i_in_data.gyro_z),
        .o_bias_x (w_bias_x),
        .o_bias_y (w_bias_y),
        .o_bias_z (w_bias_z),
        .o_status (w_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr2 <= THR2_RST;
        end else if (i_cfg_we) begin
            r_thr2 <= MAG_W'(i_cfg_wdata) * MAG_W'(i_cfg_wdata);
        end
    end

    // stage 1: registered sample and per-axis squares
    assign w_sq_x = (2*DATA_W)'(i_in_data.accel_x) * (2*DATA_W)'(i_in_data.accel_x);
    assign w_sq_y = (2*DATA_W)'(i_in_data.accel_y) * (2*DATA_W)'(i_in_data.accel_y);
    assign w_sq_z = (2*DATA_W)'(i_in_data.accel_z) * (2*DATA_W)'(i_in_data.accel_z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_ready) begin
            r_s1_valid <= w_accept && w_status.done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_ready) begin
            r_s1_in <= i_in_data;
            r_sq_x  <= w_sq_x[SQ_W-1:0];
            r_sq_y  <= w_sq_y[SQ_W-1:0];
            r_sq_z  <= w_sq_z[SQ_W-1:0];
        end
    end

    // stage 2: magnitude compare, onset, bias removal
    assign w_mag2    = MAG_W'(r_sq_x) + MAG_W'(r_sq_y) + MAG_W'(r_sq_z);
    assign w_falling = (w_mag2 < r_thr2);

    always_comb begin
        n_out.out_accel_x = r_s1_in.accel_x;
        n_out.out_accel_y = r_s1_in.accel_y;
        n_out.out_accel_z = r_s1_in.accel_z;
        n_out.rate_x      = sat_sub(r_s1_in.gyro_x, w_bias_x);
        n_out.rate_y      = sat_sub(r_s1_in.gyro_y, w_bias_y);
        n_out.rate_z      = sat_sub(r_s1_in.gyro_z, w_bias_z);
        n_out.falling     = w_falling;
        n_out.fall_onset  = w_falling && !r_in_fall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_in_fall   <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_s1_valid;
            if (r_s1_valid) begin
                r_in_fall <= w_falling;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // results only exist once the biases are final
    a_out_after_calib: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid || r_out_valid) |-> w_status.done)
        else $error("result before calibration finished");

    a_busy_done_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_status.busy && w_status.done))
        else $error("calibration busy and done together");

    a_bias_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_status.done && $past(w_status.done))
            |-> ($stable(w_bias_x) && $stable(w_bias_y) && $stable(w_bias_z)))
        else $error("bias changed after calibration");

endmodule
